### src/sli_pkg.sv
package sli_pkg;

	// Fixed field widths of the request and result channels.
	localparam int unsigned DATA_W      = 32;
	localparam int unsigned INDEX_W     = 6;
	localparam int unsigned COUNT_OUT_W = 7;
	localparam int unsigned CMD_W       = 2;

	// Command codes carried by a request.
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_INS_CMP,
		ST_INS_PLACE,
		ST_DEL_RUN,
		ST_RD_WAIT,
		ST_DONE
	} state_t;

	// Datapath operations issued by the controller, one per cycle.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_CAPTURE,
		OP_INS_START,
		OP_INS_SHIFT,
		OP_INS_PLACE,
		OP_DEL_START,
		OP_DEL_STEP,
		OP_RD_START,
		OP_RD_CAPTURE,
		OP_DROP,
		OP_INVALID,
		OP_LOAD_OUT
	} op_t;

	typedef struct packed {
		op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             count_zero;
		logic             count_full;
		logic             idx_ok;
		logic             ins_ge;
		logic             wptr_one;
		logic             del_last;
		logic             out_free;
	} dp_status_t;

endpackage

### src/sli_ctrl.sv
module sli_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  sli_pkg::dp_status_t status,
	output sli_pkg::dp_cmd_t    cmd
);

	sli_pkg::state_t state_q;
	sli_pkg::state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sli_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			sli_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = sli_pkg::ST_DISPATCH;
				end
			end
			sli_pkg::ST_DISPATCH: begin
				case (status.cmd)
					sli_pkg::CMD_INSERT: begin
						if (status.count_full) begin
							state_d = sli_pkg::ST_DONE;
						end else if (status.count_zero) begin
							state_d = sli_pkg::ST_INS_PLACE;
						end else begin
							state_d = sli_pkg::ST_INS_CMP;
						end
					end
					sli_pkg::CMD_DELETE: begin
						state_d = status.count_zero ? sli_pkg::ST_DONE : sli_pkg::ST_DEL_RUN;
					end
					sli_pkg::CMD_READ: begin
						state_d = status.idx_ok ? sli_pkg::ST_RD_WAIT : sli_pkg::ST_DONE;
					end
					default: begin
						state_d = sli_pkg::ST_DONE;
					end
				endcase
			end
			sli_pkg::ST_INS_CMP: begin
				if (!status.ins_ge || status.wptr_one) begin
					state_d = sli_pkg::ST_INS_PLACE;
				end
			end
			sli_pkg::ST_INS_PLACE: begin
				state_d = sli_pkg::ST_DONE;
			end
			sli_pkg::ST_DEL_RUN: begin
				if (status.del_last) begin
					state_d = sli_pkg::ST_DONE;
				end
			end
			sli_pkg::ST_RD_WAIT: begin
				state_d = sli_pkg::ST_DONE;
			end
			sli_pkg::ST_DONE: begin
				if (status.out_free) begin
					state_d = sli_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sli_pkg::ST_IDLE;
			end
		endcase
	end

	// Output logic: one datapath operation per cycle.
	always_comb begin
		cmd.op   = sli_pkg::OP_NONE;
		in_stall = 1'b1;
		case (state_q)
			sli_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.op = sli_pkg::OP_CAPTURE;
				end
			end
			sli_pkg::ST_DISPATCH: begin
				case (status.cmd)
					sli_pkg::CMD_INSERT: begin
						cmd.op = status.count_full ? sli_pkg::OP_DROP : sli_pkg::OP_INS_START;
					end
					sli_pkg::CMD_DELETE: begin
						cmd.op = status.count_zero ? sli_pkg::OP_NONE : sli_pkg::OP_DEL_START;
					end
					sli_pkg::CMD_READ: begin
						cmd.op = status.idx_ok ? sli_pkg::OP_RD_START : sli_pkg::OP_INVALID;
					end
					default: begin
						cmd.op = sli_pkg::OP_NONE;
					end
				endcase
			end
			sli_pkg::ST_INS_CMP: begin
				if (status.ins_ge) begin
					cmd.op = sli_pkg::OP_INS_SHIFT;
				end
			end
			sli_pkg::ST_INS_PLACE: begin
				cmd.op = sli_pkg::OP_INS_PLACE;
			end
			sli_pkg::ST_DEL_RUN: begin
				cmd.op = sli_pkg::OP_DEL_STEP;
			end
			sli_pkg::ST_RD_WAIT: begin
				cmd.op = sli_pkg::OP_RD_CAPTURE;
			end
			sli_pkg::ST_DONE: begin
				if (status.out_free) begin
					cmd.op = sli_pkg::OP_LOAD_OUT;
				end
			end
			default: begin
				cmd.op = sli_pkg::OP_NONE;
			end
		endcase
	end

endmodule

### src/sli_dpath.sv
module sli_dpath #(
	parameter int unsigned CAPACITY = 64
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  sli_pkg::dp_cmd_t                        cmd,
	output sli_pkg::dp_status_t                     status,
	input  logic [sli_pkg::CMD_W-1:0]               command,
	input  logic signed [sli_pkg::DATA_W-1:0]       value,
	input  logic [sli_pkg::INDEX_W-1:0]             index,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic [sli_pkg::COUNT_OUT_W-1:0]         count,
	output logic signed [sli_pkg::DATA_W-1:0]       read_value,
	output logic                                    full_dropped,
	output logic                                    index_invalid
);

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);

	// Entry storage: one write and one registered read per cycle.
	logic signed [sli_pkg::DATA_W-1:0] mem [CAPACITY];
	logic signed [sli_pkg::DATA_W-1:0] rd_data_q;
	logic                              we;
	logic [AW-1:0]                     waddr;
	logic [AW-1:0]                     raddr;
	logic signed [sli_pkg::DATA_W-1:0] wdata;

	// Request and working registers.
	logic [sli_pkg::CMD_W-1:0]         cmd_q;
	logic signed [sli_pkg::DATA_W-1:0] value_q;
	logic [sli_pkg::INDEX_W-1:0]       index_q;
	logic [CW-1:0]                     count_q;
	logic [CW-1:0]                     wptr_q;
	logic [CW-1:0]                     rptr_q;
	logic [CW-1:0]                     keep_q;
	logic [CW-1:0]                     keep_next;
	logic                              del_keep;

	// Result under construction and the output register.
	logic signed [sli_pkg::DATA_W-1:0] res_rd_q;
	logic                              res_drop_q;
	logic                              res_inv_q;
	logic                              out_valid_q;
	logic [sli_pkg::COUNT_OUT_W-1:0]   out_count_q;
	logic signed [sli_pkg::DATA_W-1:0] out_read_q;
	logic                              out_drop_q;
	logic                              out_inv_q;

	// Status flags toward the controller.
	assign del_keep  = rd_data_q != value_q;
	assign keep_next = keep_q + CW'(del_keep);

	always_comb begin
		status.cmd        = cmd_q;
		status.count_zero = count_q == '0;
		status.count_full = count_q == CW'(CAPACITY);
		status.idx_ok     = 32'(index_q) < 32'(count_q);
		status.ins_ge     = rd_data_q >= value_q;
		status.wptr_one   = wptr_q == CW'(1);
		status.del_last   = rptr_q == count_q;
		status.out_free   = !out_valid_q || !out_stall;
	end

	// Memory port control for each operation.
	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = rd_data_q;
		raddr = '0;
		case (cmd.op)
			sli_pkg::OP_INS_START: begin
				raddr = AW'(count_q - CW'(1));
			end
			sli_pkg::OP_INS_SHIFT: begin
				we    = 1'b1;
				waddr = AW'(wptr_q);
				raddr = AW'(wptr_q - CW'(2));
			end
			sli_pkg::OP_INS_PLACE: begin
				we    = 1'b1;
				waddr = AW'(wptr_q);
				wdata = value_q;
			end
			sli_pkg::OP_DEL_STEP: begin
				we    = del_keep;
				waddr = AW'(keep_q);
				raddr = AW'(rptr_q);
			end
			sli_pkg::OP_RD_START: begin
				raddr = AW'(index_q);
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// Storage array with registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_data_q <= mem[raddr];
	end

	// Payload and pointer registers.
	always_ff @(posedge clk) begin
		case (cmd.op)
			sli_pkg::OP_CAPTURE: begin
				cmd_q      <= command;
				value_q    <= value;
				index_q    <= index;
				res_rd_q   <= '0;
				res_drop_q <= 1'b0;
				res_inv_q  <= 1'b0;
			end
			sli_pkg::OP_INS_START: begin
				wptr_q <= count_q;
			end
			sli_pkg::OP_INS_SHIFT: begin
				wptr_q <= wptr_q - CW'(1);
			end
			sli_pkg::OP_DEL_START: begin
				rptr_q <= CW'(1);
				keep_q <= '0;
			end
			sli_pkg::OP_DEL_STEP: begin
				rptr_q <= rptr_q + CW'(1);
				keep_q <= keep_next;
			end
			sli_pkg::OP_RD_CAPTURE: begin
				res_rd_q <= rd_data_q;
			end
			sli_pkg::OP_DROP: begin
				res_drop_q <= 1'b1;
			end
			sli_pkg::OP_INVALID: begin
				res_inv_q <= 1'b1;
			end
			sli_pkg::OP_LOAD_OUT: begin
				out_count_q <= sli_pkg::COUNT_OUT_W'(count_q);
				out_read_q  <= res_rd_q;
				out_drop_q  <= res_drop_q;
				out_inv_q   <= res_inv_q;
			end
			default: begin
				wptr_q <= wptr_q;
			end
		endcase
	end

	// Entry count: grows on a placed insert, set by the last delete step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.op == sli_pkg::OP_INS_PLACE) begin
			count_q <= count_q + CW'(1);
		end else if (cmd.op == sli_pkg::OP_DEL_STEP && status.del_last) begin
			count_q <= keep_next;
		end
	end

	// Output valid: set on load, cleared when the result is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == sli_pkg::OP_LOAD_OUT) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign count         = out_count_q;
	assign read_value    = out_read_q;
	assign full_dropped  = out_drop_q;
	assign index_invalid = out_inv_q;

	// The stored count never passes the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= CAPACITY)
		else $error("entry count above capacity");

	// Compaction writes never overtake the read pointer.
	a_keep_behind: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == sli_pkg::OP_DEL_STEP |-> keep_q < rptr_q)
		else $error("delete write pointer passed read pointer");

	// A shift always moves an entry that lies inside the list.
	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == sli_pkg::OP_INS_SHIFT |-> wptr_q != '0 && wptr_q <= count_q)
		else $error("insert shift outside the list");

	// A dropped insert only happens on a full list and leaves it full.
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == sli_pkg::OP_DROP |-> status.count_full ##1 status.count_full)
		else $error("insert dropped while list not full");

	// A result never flags both a dropped insert and a bad index.
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_drop_q && out_inv_q))
		else $error("conflicting result flags");

endmodule

### src/sorted_list_insert_delete.sv
// Sorted list of signed 32-bit values, kept in ascending order in an
// on-chip memory of CAPACITY entries.
// Request channel (in_valid / in_stall): command, value, index. Command 0
// inserts value before the first entry that is not smaller, 1 deletes every
// entry equal to value, 2 reads the entry at index. An insert into a full
// list is refused and flagged by full_dropped; a read at or past the count
// sets index_invalid. Result channel (out_valid / out_stall): one result per
// request with the new count, read_value (zero unless a good read) and flags.
// One request is worked at a time. The memory has a single write and read
// port, so insert and delete walk the list one entry per cycle.
// A new request is accepted the cycle after its result is loaded, even while
// that result still waits; a stalled result holds in the output register and
// the next result waits in its final state until the register frees up.
// Reset clears the count and all control state; entry contents are left as
// they are, since no entry at or past the count is ever read.
module sorted_list_insert_delete #(
	parameter int unsigned CAPACITY = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [sli_pkg::CMD_W-1:0]         command,
	input  logic signed [sli_pkg::DATA_W-1:0] value,
	input  logic [sli_pkg::INDEX_W-1:0]       index,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [sli_pkg::COUNT_OUT_W-1:0]   count,
	output logic signed [sli_pkg::DATA_W-1:0] read_value,
	output logic                              full_dropped,
	output logic                              index_invalid
);

	sli_pkg::dp_cmd_t    dp_cmd;
	sli_pkg::dp_status_t dp_status;

	// Sequencer for the scan, shift and compaction passes.
	sli_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (dp_status),
		.cmd      (dp_cmd)
	);

	// Entry memory, pointers, compares and the output register.
	sli_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (dp_cmd),
		.status        (dp_status),
		.command       (command),
		.value         (value),
		.index         (index),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.count         (count),
		.read_value    (read_value),
		.full_dropped  (full_dropped),
		.index_invalid (index_invalid)
	);

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;

	localparam int unsigned LIST_CAP = 64;

	// Command code 3 has no name in the package; the block treats it as a no-op.
	localparam logic [sli_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [sli_pkg::COUNT_OUT_W-1:0]   count;
		logic signed [sli_pkg::DATA_W-1:0] read_value;
		logic                              full_dropped;
		logic                              index_invalid;
	} list_result_t;

	logic                              clk           = 1'b0;
	logic                              arst_n        = 1'b0;
	logic                              in_valid      = 1'b0;
	logic                              in_stall;
	logic [sli_pkg::CMD_W-1:0]         command       = '0;
	logic signed [sli_pkg::DATA_W-1:0] value         = '0;
	logic [sli_pkg::INDEX_W-1:0]       index         = '0;
	logic                              out_valid;
	logic                              out_stall     = 1'b0;
	logic [sli_pkg::COUNT_OUT_W-1:0]   count;
	logic signed [sli_pkg::DATA_W-1:0] read_value;
	logic                              full_dropped;
	logic                              index_invalid;

	// Shadow copy of the sorted list and the results still in flight.
	logic signed [sli_pkg::DATA_W-1:0] list_shadow[$];
	list_result_t                      pending_results[$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int mismatch_count = 0;

	sorted_list_insert_delete #(
		.CAPACITY(LIST_CAP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.value(value),
		.index(index),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.count(count),
		.read_value(read_value),
		.full_dropped(full_dropped),
		.index_invalid(index_invalid)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Apply one request to the shadow list and return the result it should produce.
	function automatic list_result_t apply_to_shadow(input logic [sli_pkg::CMD_W-1:0] cmd,
			input logic signed [sli_pkg::DATA_W-1:0] val,
			input logic [sli_pkg::INDEX_W-1:0] idx);
		list_result_t res;
		int           pos;
		res = '0;
		case (cmd)
			sli_pkg::CMD_INSERT: begin
				if (list_shadow.size() >= LIST_CAP) begin
					res.full_dropped = 1'b1;
				end else begin
					// Equal entries stay after the new value.
					pos = 0;
					while (pos < list_shadow.size() && list_shadow[pos] < val)
						pos++;
					list_shadow.insert(pos, val);
				end
			end
			sli_pkg::CMD_DELETE: begin
				for (int k = list_shadow.size() - 1; k >= 0; k--)
					if (list_shadow[k] == val)
						list_shadow.delete(k);
			end
			sli_pkg::CMD_READ: begin
				if (idx < list_shadow.size())
					res.read_value = list_shadow[idx];
				else
					res.index_invalid = 1'b1;
			end
			default: begin
			end
		endcase
		res.count = sli_pkg::COUNT_OUT_W'(list_shadow.size());
		return res;
	endfunction

	// Values cluster in a narrow band so that duplicates and delete hits are common.
	function automatic logic signed [sli_pkg::DATA_W-1:0] pick_value();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 45)
			return sli_pkg::DATA_W'(int'($urandom_range(16)) - 8);
		if (roll < 60) begin
			case ($urandom_range(4))
				0: return 32'sh8000_0000;
				1: return 32'sh7FFF_FFFF;
				2: return -32'sd1;
				3: return 32'sh8000_0001;
				default: return 32'sh7FFF_FFFE;
			endcase
		end
		return $urandom;
	endfunction

	// Mostly pick a value that is present, so deletes actually remove something.
	function automatic logic signed [sli_pkg::DATA_W-1:0] pick_delete_value();
		if (list_shadow.size() > 0 && $urandom_range(99) < 75)
			return list_shadow[$urandom_range(list_shadow.size() - 1)];
		return pick_value();
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] MISMATCH: %s", $realtime, what);
		mismatch_count++;
	endtask

	// Present one request, hold it until accepted, then record its expected result.
	task automatic send_request(input logic [sli_pkg::CMD_W-1:0] cmd,
			input logic signed [sli_pkg::DATA_W-1:0] val,
			input logic [sli_pkg::INDEX_W-1:0] idx);
		list_result_t expected;
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			command  <= sli_pkg::CMD_W'($urandom);
			value    <= $urandom;
			index    <= sli_pkg::INDEX_W'($urandom);
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		command  <= cmd;
		value    <= val;
		index    <= idx;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expected = apply_to_shadow(cmd, val, idx);
		pending_results.insert(pending_results.size(), expected);
	endtask

	// Check each accepted result against the oldest expectation, and drive back-pressure.
	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result arrived with no request outstanding");
			end else begin
				want = pending_results.pop_front();
				if (count !== want.count)
					report_mismatch($sformatf("count %0d, expected %0d",
						count, want.count));
				if (read_value !== want.read_value)
					report_mismatch($sformatf("read_value %0d, expected %0d",
						read_value, want.read_value));
				if (full_dropped !== want.full_dropped)
					report_mismatch($sformatf("full_dropped %b, expected %b",
						full_dropped, want.full_dropped));
				if (index_invalid !== want.index_invalid)
					report_mismatch($sformatf("index_invalid %b, expected %b",
						index_invalid, want.index_invalid));
			end
		end
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Empty-list corners, signed extremes, duplicates and every command code.
	task automatic test_directed_ops();
		send_request(sli_pkg::CMD_READ, 32'sd0, 6'd0);
		send_request(sli_pkg::CMD_READ, 32'sd0, 6'd63);
		send_request(sli_pkg::CMD_DELETE, 32'sd0, 6'd0);
		send_request(CMD_UNUSED, -32'sd1, 6'd63);
		send_request(sli_pkg::CMD_INSERT, 32'sh7FFF_FFFF, 6'd0);
		send_request(sli_pkg::CMD_INSERT, 32'sh8000_0000, 6'd0);
		send_request(sli_pkg::CMD_INSERT, 32'sd0, 6'd0);
		send_request(sli_pkg::CMD_INSERT, -32'sd1, 6'd0);
		send_request(sli_pkg::CMD_INSERT, 32'sd1, 6'd0);
		send_request(sli_pkg::CMD_INSERT, 32'sd0, 6'd0);
		send_request(sli_pkg::CMD_INSERT, 32'sh8000_0000, 6'd0);
		send_request(sli_pkg::CMD_READ, 32'sd0, 6'd0);
		send_request(sli_pkg::CMD_READ, 32'sd0, 6'd6);
		send_request(sli_pkg::CMD_READ, 32'sd0, 6'd7);
		send_request(sli_pkg::CMD_READ, 32'sd0, 6'd3);
		send_request(sli_pkg::CMD_DELETE, 32'sd0, 6'd0);
		send_request(sli_pkg::CMD_DELETE, 32'sd5, 6'd0);
		send_request(sli_pkg::CMD_DELETE, 32'sh8000_0000, 6'd0);
		send_request(sli_pkg::CMD_READ, 32'sd0, 6'd0);
		send_request(sli_pkg::CMD_DELETE, 32'sh7FFF_FFFF, 6'd0);
		send_request(sli_pkg::CMD_READ, 32'sd0, 6'd2);
	endtask

	// Fill the list to capacity, hit it with refused inserts, then drain it.
	task automatic test_full_list();
		while (list_shadow.size() < LIST_CAP)
			send_request(sli_pkg::CMD_INSERT, sli_pkg::DATA_W'(int'($urandom_range(3))),
				6'($urandom));
		send_request(sli_pkg::CMD_INSERT, 32'sh7FFF_FFFF, 6'd0);
		send_request(sli_pkg::CMD_INSERT, 32'sh8000_0000, 6'd0);
		send_request(sli_pkg::CMD_READ, 32'sd0, 6'd63);
		send_request(sli_pkg::CMD_READ, 32'sd0, 6'd0);
		send_request(CMD_UNUSED, 32'sh5A5A_A5A5, 6'd21);
		while (list_shadow.size() > 0)
			send_request(sli_pkg::CMD_DELETE, list_shadow[0], 6'd0);
		send_request(sli_pkg::CMD_READ, 32'sd0, 6'd0);
	endtask

	// Random traffic that alternates between filling the list and draining it.
	task automatic test_random_traffic(input int n_requests, input int send_pct,
			input int stall_pct);
		int unsigned                       roll;
		int                                ins_pct;
		int                                del_pct;
		bit                                filling;
		logic [sli_pkg::CMD_W-1:0]         cmd;
		logic signed [sli_pkg::DATA_W-1:0] val;
		logic [sli_pkg::INDEX_W-1:0]       idx;
		send_idle_pct  = send_pct;
		recv_stall_pct = stall_pct;
		filling = 1'b1;
		repeat (n_requests) begin
			if (list_shadow.size() >= LIST_CAP && $urandom_range(3) == 0)
				filling = 1'b0;
			else if (list_shadow.size() < 4)
				filling = 1'b1;
			ins_pct = filling ? 80 : 30;
			del_pct = filling ? 5 : 40;
			roll = $urandom_range(99);
			val  = $urandom;
			idx  = sli_pkg::INDEX_W'($urandom);
			if (roll < 3) begin
				cmd = CMD_UNUSED;
			end else if (roll < 3 + ins_pct) begin
				cmd = sli_pkg::CMD_INSERT;
				val = pick_value();
			end else if (roll < 3 + ins_pct + del_pct) begin
				cmd = sli_pkg::CMD_DELETE;
				val = pick_delete_value();
			end else begin
				cmd = sli_pkg::CMD_READ;
				if (list_shadow.size() > 0 && $urandom_range(99) < 80)
					idx = sli_pkg::INDEX_W'($urandom_range(list_shadow.size() - 1));
			end
			send_request(cmd, val, idx);
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_ops();
		test_full_list();
		test_random_traffic(115, 0, 0);
		test_random_traffic(115, 61, 0);
		test_random_traffic(115, 0, 61);
		test_random_traffic(115, 22, 22);
		in_valid <= 1'b0;

		// Let the last results drain, then allow for a worst-case insert walk.
		while (pending_results.size() > 0)
			@(posedge clk);
		repeat (LIST_CAP + 16) @(posedge clk);

		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Hard stop in case the block hangs.
	initial begin
		#5000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
